// ===== rtl/core/asms_pkg.sv =====
// Shared types, constants and helper functions for the ADC scan median sequencer.
// No dependencies; imported by asms_history, adc_scan_median_sequencer and the testbench.
package asms_pkg;

	localparam int HISTORY_DEPTH = 3;
	localparam int NUM_CHAN      = 3;
	localparam int CODE_W        = 15;
	localparam int RAW_W         = 16;
	localparam int RATE_W        = 16;
	localparam int WORD_W        = 16;
	localparam int WAIT_W        = 17;

	typedef enum logic [1:0] {
		CH_A0 = 2'd0,
		CH_A1 = 2'd1,
		CH_A2 = 2'd2
	} chan_t;

	typedef enum logic [1:0] {
		MODE_THREE   = 2'd0,
		MODE_A0_A2   = 2'd1,
		MODE_A1_A2   = 2'd2,
		MODE_A0_ONLY = 2'd3
	} mode_t;

	typedef enum logic {
		REG_CHANNEL_MODE   = 1'b0,
		REG_REQUESTED_RATE = 1'b1
	} reg_idx_t;

	localparam logic [WORD_W-1:0] BASE_A0 = 16'hC303;
	localparam logic [WORD_W-1:0] BASE_A1 = 16'hD303;
	localparam logic [WORD_W-1:0] BASE_A2 = 16'hE303;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd860;

	typedef logic [CODE_W-1:0] code_t;
	typedef code_t [NUM_CHAN-1:0] level_vec_t;

	typedef struct packed {
		logic [WORD_W-1:0] dr_bits;
		logic [WAIT_W-1:0] wait_us;
	} rate_sel_t;

	function automatic code_t med3(input code_t x, input code_t y, input code_t z);
		code_t r;
		if ((x <= y && y <= z) || (z <= y && y <= x))
			r = y;
		else if ((y <= x && x <= z) || (z <= x && x <= y))
			r = x;
		else
			r = z;
		return r;
	endfunction

	// Map the requested rate down to the nearest supported data rate.
	function automatic rate_sel_t rate_map(input logic [RATE_W-1:0] sps);
		rate_sel_t r;
		if (sps >= 16'd860)      r = '{16'h00E0, 17'd1165};
		else if (sps >= 16'd475) r = '{16'h00C0, 17'd2110};
		else if (sps >= 16'd250) r = '{16'h00A0, 17'd4010};
		else if (sps >= 16'd128) r = '{16'h0080, 17'd7820};
		else if (sps >= 16'd64)  r = '{16'h0060, 17'd15630};
		else if (sps >= 16'd32)  r = '{16'h0040, 17'd31260};
		else if (sps >= 16'd16)  r = '{16'h0020, 17'd62510};
		else                     r = '{16'h0000, 17'd125020};
		return r;
	endfunction

endpackage

// ===== rtl/core/asms_history.sv =====
// Per-channel sample history and median-of-three filtered levels.
// Depends on asms_pkg.
module asms_history
	import asms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd_en,
	input  chan_t      chan,
	input  code_t      code,
	output level_vec_t level_next
);

	code_t [NUM_CHAN-1:0][HISTORY_DEPTH-1:0] hist_q;
	level_vec_t level_q;
	code_t      med;

	// Median over the new code and the two newest entries already held.
	assign med = med3(code, hist_q[chan][0], hist_q[chan][1]);

	always_comb begin
		level_next = level_q;
		level_next[chan] = med;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			level_q <= '0;
		end else if (upd_en) begin
			for (int k = HISTORY_DEPTH - 1; k > 0; k--)
				hist_q[chan][k] <= hist_q[chan][k-1];
			hist_q[chan][0] <= code;
			level_q[chan]   <= med;
		end
	end

endmodule

// ===== rtl/core/adc_scan_median_sequencer.sv =====
// Pipeline: a sample transfer passes the input register, then the result register; the
// input register loads at the accepting edge, the result register when stage 1 advances.
// Throughput: one sample per cycle unless result_stall holds; chan_q alone closes the channel loop.
// Reset: asynchronous, active low; clears history, levels, channel (A0),
// mode (three channels) and rate (860 sps). No clearing pass is needed.
module adc_scan_median_sequencer
	import asms_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     write_en,
	input  logic                     write_index,
	input  logic [RATE_W-1:0]        write_data,
	// sample channel
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic signed [RAW_W-1:0]  raw_sample,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [1:0]               sampled_channel,
	output logic [WORD_W-1:0]        next_trigger_word,
	output logic [WAIT_W-1:0]        next_wait_us,
	output logic                     frame_ready,
	output logic [CODE_W-1:0]        level_zero,
	output logic [CODE_W-1:0]        level_one,
	output logic [CODE_W-1:0]        level_two
);

	// Configuration registers.
	mode_t             mode_q;
	logic [RATE_W-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_THREE;
			rate_q <= RATE_RESET;
		end else if (write_en) begin
			case (reg_idx_t'(write_index))
				REG_CHANNEL_MODE:   mode_q <= mode_t'(write_data[1:0]);
				REG_REQUESTED_RATE: rate_q <= write_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input register holding the clamped code.
	logic  valid_s1;
	code_t code_s1;
	logic  adv_s1;
	logic  take_in;

	// Advance stage 1 when it holds a code and the result register is empty or being drained.
	assign adv_s1       = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !adv_s1;
	assign take_in      = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in || adv_s1)
			valid_s1 <= take_in;
	end

	// Clamp negative codes to zero on the way in.
	always_ff @(posedge clk) begin
		if (take_in)
			code_s1 <= raw_sample[RAW_W-1] ? '0 : code_t'(raw_sample[CODE_W-1:0]);
	end

	// Channel sequencer state.
	chan_t chan_q;
	chan_t chan_next;
	logic  frame_d;

	always_comb begin
		frame_d   = 1'b0;
		chan_next = CH_A0;
		case (chan_q)
			CH_A0: begin
				case (mode_q)
					MODE_A0_ONLY: begin
						chan_next = CH_A0;
						frame_d   = 1'b1;
					end
					MODE_A0_A2: chan_next = CH_A2;
					default:    chan_next = CH_A1;
				endcase
			end
			CH_A1: chan_next = CH_A2;
			CH_A2: begin
				frame_d   = 1'b1;
				chan_next = (mode_q == MODE_A1_A2) ? CH_A1 : CH_A0;
			end
			default: chan_next = CH_A1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chan_q <= CH_A0;
		else if (adv_s1)
			chan_q <= chan_next;
	end

	// History and median filter.
	level_vec_t level_d;

	asms_history u_history (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_en     (adv_s1),
		.chan       (chan_q),
		.code       (code_s1),
		.level_next (level_d)
	);

	// Trigger word and wait time for the next channel.
	rate_sel_t         rate_sel;
	logic [WORD_W-1:0] base_d;

	assign rate_sel = rate_map(rate_q);

	always_comb begin
		case (chan_next)
			CH_A0:   base_d = BASE_A0;
			CH_A1:   base_d = BASE_A1;
			CH_A2:   base_d = BASE_A2;
			default: base_d = BASE_A0;
		endcase
	end

	// Stage 2: result register; hold while stalled.
	logic              valid_s2;
	chan_t             chan_s2;
	logic [WORD_W-1:0] word_s2;
	logic [WAIT_W-1:0] wait_s2;
	logic              frame_s2;
	level_vec_t        level_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1)
			valid_s2 <= 1'b1;
		else if (!result_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chan_s2  <= chan_q;
			word_s2  <= base_d | rate_sel.dr_bits;
			wait_s2  <= rate_sel.wait_us;
			frame_s2 <= frame_d;
			level_s2 <= level_d;
		end
	end

	assign result_valid      = valid_s2;
	assign sampled_channel   = chan_s2;
	assign next_trigger_word = word_s2;
	assign next_wait_us      = wait_s2;
	assign frame_ready       = frame_s2;
	assign level_zero        = level_s2[0];
	assign level_one         = level_s2[1];
	assign level_two         = level_s2[2];

endmodule

// ===== tb/tb_adc_scan_median_sequencer.sv =====
// Self-checking testbench for adc_scan_median_sequencer: median-of-three filtering per
// channel, channel sequencing by mode, and trigger word / wait time by rate.
// Depends on asms_pkg and the adc_scan_median_sequencer RTL only.
module tb_adc_scan_median_sequencer;
	import asms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One result transfer as the block should present it.
	typedef struct {
		logic [1:0]        chan;
		logic [WORD_W-1:0] trigger;
		logic [WAIT_W-1:0] conv_wait;
		logic              frame;
		code_t             lvl0;
		code_t             lvl1;
		code_t             lvl2;
	} scan_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    write_en = 1'b0;
	logic                    write_index = 1'b0;
	logic [RATE_W-1:0]       write_data = '0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic signed [RAW_W-1:0] raw_sample = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [1:0]              sampled_channel;
	logic [WORD_W-1:0]       next_trigger_word;
	logic [WAIT_W-1:0]       next_wait_us;
	logic                    frame_ready;
	logic [CODE_W-1:0]       level_zero;
	logic [CODE_W-1:0]       level_one;
	logic [CODE_W-1:0]       level_two;

	adc_scan_median_sequencer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.write_en         (write_en),
		.write_index      (write_index),
		.write_data       (write_data),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.raw_sample       (raw_sample),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.sampled_channel  (sampled_channel),
		.next_trigger_word(next_trigger_word),
		.next_wait_us     (next_wait_us),
		.frame_ready      (frame_ready),
		.level_zero       (level_zero),
		.level_one        (level_one),
		.level_two        (level_two)
	);

	// Samples waiting to be offered, and results the filter should produce, oldest first.
	logic signed [RAW_W-1:0] pending_samples[$];
	scan_result_t            expected_results[$];

	// Shadow copy of the block's state and registers, advanced on every sample transfer.
	mode_t             mode_shadow = MODE_THREE;
	logic [RATE_W-1:0] rate_shadow = RATE_RESET;
	chan_t             scan_chan = CH_A0;
	code_t             chan_history [NUM_CHAN][HISTORY_DEPTH] = '{default: '0};
	code_t             chan_level [NUM_CHAN] = '{default: '0};

	// Lowest rate of each supported band, fastest first, with its conversion time.
	logic [RATE_W-1:0] band_floor [8] = '{16'd860, 16'd475, 16'd250, 16'd128,
	                                      16'd64, 16'd32, 16'd16, 16'd0};
	logic [WAIT_W-1:0] band_wait [8] = '{17'd1165, 17'd2110, 17'd4010, 17'd7820,
	                                     17'd15630, 17'd31260, 17'd62510, 17'd125020};
	// Rates on and just below each band edge.
	logic [RATE_W-1:0] rate_edges [16] = '{16'd0, 16'd15, 16'd16, 16'd31, 16'd32, 16'd63,
	                                       16'd64, 16'd127, 16'd128, 16'd249, 16'd250,
	                                       16'd474, 16'd475, 16'd859, 16'd860, 16'hFFFF};

	// Directed codes: full-scale, negative clamps, ties and every mode.
	logic signed [RAW_W-1:0] directed_codes [24] = '{
		16'sh7FFF, -16'sd1, 16'sd0, -16'sh8000, 16'sd1, 16'sh4000, 16'sd500, 16'sd1,
		16'sh4000,
		16'sd12345, -16'sd5, 16'sd7, 16'sh7FFE, 16'sd7,
		16'sh2AAA, 16'sh5555, 16'sh7FFF, -16'sd2, 16'sh7FFF,
		16'sd3, 16'sd3, -16'sh8000, 16'sh1234, 16'sd3};
	int    segment_len [4] = '{9, 5, 5, 5};
	mode_t segment_mode [4] = '{MODE_THREE, MODE_A1_A2, MODE_A0_ONLY, MODE_A0_A2};
	logic [RATE_W-1:0] segment_rate [4] = '{16'd860, 16'hFFFF, 16'd0, 16'd475};

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int holdoff_requests = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int mismatches = 0;
	int results_checked = 0;
	int frames_seen = 0;
	int settings_used = 0;

	function automatic code_t median3(input code_t a, input code_t b, input code_t c);
		code_t lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo)
			return lo;
		else if (c >= hi)
			return hi;
		return c;
	endfunction

	// Advance the shadow state by one sample and return what the block should answer.
	function automatic scan_result_t predict_scan_step(input logic signed [RAW_W-1:0] raw);
		scan_result_t r;
		chan_t ch, nxt;
		code_t code;
		logic [WORD_W-1:0] base;
		int band;
		ch = scan_chan;
		// Negative codes enter the history as zero.
		code = raw[RAW_W-1] ? code_t'(0) : code_t'(raw[CODE_W-1:0]);
		for (int k = HISTORY_DEPTH - 1; k > 0; k--)
			chan_history[ch][k] = chan_history[ch][k-1];
		chan_history[ch][0] = code;
		chan_level[ch] = median3(chan_history[ch][0], chan_history[ch][1],
			chan_history[ch][2]);

		r.frame = 1'b0;
		case (ch)
			CH_A0: begin
				case (mode_shadow)
					MODE_A0_ONLY: begin
						nxt = CH_A0;
						r.frame = 1'b1;
					end
					MODE_A0_A2: nxt = CH_A2;
					default:    nxt = CH_A1;
				endcase
			end
			CH_A1: nxt = CH_A2;
			default: begin
				// A2 closes a frame; A1/A2 mode never returns to A0.
				r.frame = 1'b1;
				nxt = (mode_shadow == MODE_A1_A2) ? CH_A1 : CH_A0;
			end
		endcase
		scan_chan = nxt;

		// Pick the fastest band whose floor the requested rate reaches.
		band = 7;
		for (int i = 7; i >= 0; i--)
			if (rate_shadow >= band_floor[i])
				band = i;
		base = (nxt == CH_A0) ? BASE_A0 : (nxt == CH_A1) ? BASE_A1 : BASE_A2;

		r.chan = ch;
		r.trigger = base | {8'h00, 3'(7 - band), 5'b00000};
		r.conv_wait = band_wait[band];
		r.lvl0 = chan_level[0];
		r.lvl1 = chan_level[1];
		r.lvl2 = chan_level[2];
		return r;
	endfunction

	function automatic logic signed [RAW_W-1:0] random_code(input logic signed [RAW_W-1:0] prev);
		logic signed [RAW_W-1:0] v;
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(4))
					0: v = 16'sh7FFF;
					1: v = -16'sh8000;
					2: v = -16'sd1;
					3: v = 16'sd1;
					default: v = 16'sd0;
				endcase
			end
			// Stay near the last code so that histories hold ties and close values.
			1: v = prev + RAW_W'($urandom_range(6)) - 16'sd3;
			default: v = RAW_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [RATE_W-1:0] data);
		@(posedge clk);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_en <= 1'b0;
		// The write landed at this edge; mirror it.
		if (idx == REG_CHANNEL_MODE)
			mode_shadow = mode_t'(data[1:0]);
		else
			rate_shadow = data;
	endtask

	// Write both registers; upper mode bits carry noise the block must ignore.
	task automatic configure(input mode_t m, input logic [RATE_W-1:0] rate);
		logic [RATE_W-1:0] mode_word;
		mode_word = RATE_W'($urandom);
		mode_word[1:0] = m;
		write_register(REG_CHANNEL_MODE, mode_word);
		write_register(REG_REQUESTED_RATE, rate);
		settings_used++;
	endtask

	// Wait until every queued sample is through and every result has come back.
	task automatic drain;
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Free-running clock.
	initial begin
		forever #2 clk = ~clk;
	end

	// Hold reset from the start, then release it for good.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sample driver: offer the oldest pending code, hold it while stalled, idle at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(sample_valid && sample_stall)) begin
				if (sample_valid) begin
					// Transfer completed at this edge: predict and retire it.
					expected_results.push_back(predict_scan_step(raw_sample));
					void'(pending_samples.pop_front());
				end
				if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					sample_valid <= 1'b1;
					raw_sample <= pending_samples[0];
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer against the oldest prediction, then pick the
	// stall for the next cycle.
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no expected entry: sampled_channel %0d", sampled_channel);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("sampled_channel", want.chan, sampled_channel);
					check_field("next_trigger_word", want.trigger, next_trigger_word);
					check_field("next_wait_us", want.conv_wait, next_wait_us);
					check_field("frame_ready", want.frame, frame_ready);
					check_field("level_zero", want.lvl0, level_zero);
					check_field("level_one", want.lvl1, level_one);
					check_field("level_two", want.lvl2, level_two);
					results_checked++;
					if (frame_ready)
						frames_seen++;
				end
			end
			// A new hold-off request starts a long stall counted here.
			if (holdoff_requests != holdoff_seen) begin
				holdoff_seen = holdoff_requests;
				holdoff_left = 64;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Stimulus: directed segments over every mode, then random phases with varied pressure.
	initial begin
		int idx;
		int profile;
		int count;
		mode_t m;
		logic [RATE_W-1:0] rate;
		logic signed [RAW_W-1:0] last_code;
		int sender_profile [4];
		int receiver_profile [4];
		sender_profile = '{0, 69, 0, 18};
		receiver_profile = '{0, 0, 69, 18};

		while (!arst_n)
			@(negedge clk);
		@(negedge clk);

		// Directed part. The first segment runs on the reset register values.
		idx = 0;
		for (int s = 0; s < 4; s++) begin
			if (s != 0)
				configure(segment_mode[s], segment_rate[s]);
			for (int k = 0; k < segment_len[s]; k++) begin
				pending_samples.push_back(directed_codes[idx]);
				idx++;
			end
			drain();
		end

		// Random part: eight phases, each with fresh registers and an idling profile.
		last_code = '0;
		for (int p = 0; p < 8; p++) begin
			profile = p % 4;
			m = (p < 4) ? mode_t'(3 - p) : mode_t'($urandom_range(3));
			rate = ($urandom_range(3) == 0) ? RATE_W'($urandom) : rate_edges[$urandom_range(15)];
			configure(m, rate);
			sender_idle_pct = sender_profile[profile];
			receiver_stall_pct = receiver_profile[profile];
			count = 92;
			// Long receiver hold-off with the sender offering every cycle: the block
			// fills up and has to stall its input.
			if (p == 0)
				holdoff_requests++;
			for (int k = 0; k < count; k++) begin
				last_code = random_code(last_code);
				pending_samples.push_back(last_code);
				// Pause the sender until every result is back, then carry on.
				if (p == 1 && k == count / 2)
					drain();
			end
			drain();
		end

		$display("Summary: %0d results checked over %0d register settings, %0d frames flagged.",
			results_checked, settings_used, frames_seen);
		$display("Covered all four channel modes, rate band edges, clamps, ties and stalls.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
